FILE: design/idw_pkg.sv
// shared types and constants for the incremental dtw distance block
// no dependencies
package idw_pkg;

  localparam int MAX_LEN = 128;
  localparam int IDX_W   = $clog2(MAX_LEN);
  localparam int LEN_W   = IDX_W + 1;
  localparam int CELL_W  = 2 * IDX_W;
  localparam int COST_W  = 40;
  localparam int STEP_W  = 8;
  localparam int COORD_W = 16;
  localparam int SAMP_W  = 3 * COORD_W;
  localparam int RAD_W   = 34;
  localparam int ROOT_W  = RAD_W / 2;
  localparam int REM_W   = ROOT_W + 3;
  localparam int PROD_W  = COST_W + COORD_W;

  localparam logic [COST_W-1:0] COST_MAX = {COST_W{1'b1}};
  localparam logic [STEP_W-1:0] STEP_MAX = {STEP_W{1'b1}};

  typedef enum logic [1:0] {
    ACT_RESTART = 2'd0,
    ACT_TMPL    = 2'd1,
    ACT_SIG     = 2'd2,
    ACT_BOTH    = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_FULL     = 2'd1,
    ST_NO_START = 2'd2
  } status_t;

  typedef enum logic {
    CFG_FORGET = 1'b0,
    CFG_DIMS   = 1'b1
  } cfg_idx_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_RD,
    S_SQ,
    S_SQRT,
    S_SEL,
    S_SCL,
    S_WR,
    S_FRD,
    S_FLAT,
    S_DIV,
    S_DONE
  } state_t;

endpackage

FILE: design/incremental_dtw_distance.sv
// Incremental DTW distance engine. One cell is filled at a time by a shared
// 40x16 multiplier, a square root that settles one root bit per cycle and a
// one-bit-per-cycle divider. Each cell is read, squared once per coordinate
// used, rooted, selected, scaled and written; an append fills the new row or
// column, both for a combined append, then the final cell is read, the average
// divided and the result loaded. A restart and a refused append on a full table
// also read the final cell; an append before any restart goes straight to the
// result. Every result waits while the output stalls.
// in_stall stays high from the transfer of an item until its result is loaded.
// Depends on idw_pkg.
module incremental_dtw_distance (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_action,
  input  logic signed [15:0] in_tmpl_x,
  input  logic signed [15:0] in_tmpl_y,
  input  logic signed [15:0] in_tmpl_z,
  input  logic signed [15:0] in_sig_x,
  input  logic signed [15:0] in_sig_y,
  input  logic signed [15:0] in_sig_z,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] out_avg_distance,
  output logic [39:0] out_total_cost,
  output logic [7:0]  out_path_steps,
  output logic [1:0]  out_status,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [15:0] cfg_data
);

  localparam int IW = idw_pkg::IDX_W;
  localparam int LW = idw_pkg::LEN_W;
  localparam int CW = idw_pkg::COST_W;
  localparam int SW = idw_pkg::STEP_W;
  localparam int EW = idw_pkg::COST_W + idw_pkg::STEP_W;

  idw_pkg::state_t state_r, state_nxt;

  logic [15:0] ff_r;
  logic [1:0]  dims_r;
  logic [LW-1:0] tl_r, sl_r;
  logic [IW-1:0] line_r, pos_r;
  logic pass_col_r, pend_col_r;
  logic [1:0] status_r;
  logic [5:0] cnt_r;

  logic [EW-1:0] cmem [idw_pkg::MAX_LEN*idw_pkg::MAX_LEN];
  logic [idw_pkg::SAMP_W-1:0] tmem [idw_pkg::MAX_LEN];
  logic [idw_pkg::SAMP_W-1:0] smem [idw_pkg::MAX_LEN];
  logic [EW-1:0] c_q;
  logic [idw_pkg::SAMP_W-1:0] t_q, s_q;

  logic [idw_pkg::RAD_W-1:0] acc_r;
  logic [idw_pkg::REM_W-1:0] rem_r;
  logic [idw_pkg::ROOT_W-1:0] root_r;
  logic [CW-1:0] pred_r, scaled_r, run_c_r, dg_c_r;
  logic [SW-1:0] ps_r, run_s_r, dg_s_r;
  logic [CW-1:0] dq_r;
  logic [SW-1:0] div_r, rm_r;

  logic accept, need_t, need_s, load_out;
  logic [1:0] n_dims;
  logic [LW-1:0] last_pos;
  logic [IW-1:0] ti, sj, line_m1;
  logic [idw_pkg::CELL_W-1:0] side_addr, cell_addr, fin_addr;
  logic [15:0] tc, sc, mag;
  logic [16:0] diff;
  logic [CW-1:0] mul_a;
  logic [15:0] mul_b;
  logic [idw_pkg::PROD_W-1:0] prod;
  logic [idw_pkg::REM_W-1:0] rem_sh, trial;
  logic [CW-1:0] l_c, u_c, side_c, new_c;
  logic [SW-1:0] l_s, u_s, side_s, new_s;
  logic [CW:0] sum;
  logic [SW:0] dv;
  logic [EW-1:0] wdata;
  logic [idw_pkg::CELL_W-1:0] waddr;
  logic cwe;

  assign accept   = in_valid && !in_stall;
  assign in_stall = (state_r != idw_pkg::S_IDLE);
  assign need_t   = in_action[0];
  assign need_s   = in_action[1];
  assign n_dims   = (dims_r == 2'd0) ? 2'd1 : dims_r;
  assign last_pos = (pass_col_r ? tl_r : sl_r) - LW'(1);
  assign line_m1  = line_r - IW'(1);
  assign ti = pass_col_r ? pos_r : line_r;
  assign sj = pass_col_r ? line_r : pos_r;
  assign side_addr = pass_col_r ? {pos_r, line_m1} : {line_m1, pos_r};
  assign cell_addr = {ti, sj};
  assign fin_addr  = {IW'(tl_r - LW'(1)), IW'(sl_r - LW'(1))};
  assign load_out  = (state_r == idw_pkg::S_DONE) && (!out_valid || !out_stall);

  // coordinate difference and magnitude
  always_comb begin
    unique case (cnt_r[1:0])
      2'd0:    begin tc = t_q[15:0];  sc = s_q[15:0];  end
      2'd1:    begin tc = t_q[31:16]; sc = s_q[31:16]; end
      default: begin tc = t_q[47:32]; sc = s_q[47:32]; end
    endcase
    diff = {tc[15], tc} - {sc[15], sc};
    mag  = diff[16] ? 16'(-diff) : diff[15:0];
  end

  // shared multiplier
  always_comb begin
    if (state_r == idw_pkg::S_SQ) begin
      mul_a = CW'(mag);
      mul_b = mag;
    end else begin
      mul_a = pred_r;
      mul_b = ff_r;
    end
    prod = idw_pkg::PROD_W'(mul_a) * idw_pkg::PROD_W'(mul_b);
  end

  assign rem_sh = {rem_r[idw_pkg::REM_W-3:0], acc_r[idw_pkg::RAD_W-1 -: 2]};
  assign trial  = {1'b0, root_r, 2'b01};

  assign side_c = c_q[EW-1:SW];
  assign side_s = c_q[SW-1:0];
  assign l_c = pass_col_r ? side_c : run_c_r;
  assign l_s = pass_col_r ? side_s : run_s_r;
  assign u_c = pass_col_r ? run_c_r : side_c;
  assign u_s = pass_col_r ? run_s_r : side_s;

  assign sum   = {1'b0, scaled_r} + (CW+1)'(root_r);
  assign new_c = sum[CW] ? idw_pkg::COST_MAX : sum[CW-1:0];
  assign new_s = (ps_r == idw_pkg::STEP_MAX) ? ps_r : ps_r + SW'(1);
  assign dv    = {rm_r, dq_r[CW-1]};

  // table write port
  always_comb begin
    cwe   = 1'b0;
    waddr = cell_addr;
    wdata = {new_c, new_s};
    if (accept && in_action == idw_pkg::ACT_RESTART) begin
      cwe   = 1'b1;
      waddr = '0;
      wdata = '0;
    end else if (state_r == idw_pkg::S_WR) begin
      cwe = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cwe) cmem[waddr] <= wdata;
    if (state_r == idw_pkg::S_RD) c_q <= cmem[side_addr];
    else if (state_r == idw_pkg::S_FRD) c_q <= cmem[fin_addr];
  end

  // samples are stored only for a restart or an append that goes ahead
  always_ff @(posedge clk) begin
    if (accept && (in_action == idw_pkg::ACT_RESTART ||
                   (need_t && state_nxt == idw_pkg::S_RD)))
      tmem[(in_action == idw_pkg::ACT_RESTART) ? IW'(0) : IW'(tl_r)] <=
        {in_tmpl_z, in_tmpl_y, in_tmpl_x};
    if (state_r == idw_pkg::S_RD) t_q <= tmem[ti];
  end

  always_ff @(posedge clk) begin
    if (accept && (in_action == idw_pkg::ACT_RESTART ||
                   (need_s && state_nxt == idw_pkg::S_RD)))
      smem[(in_action == idw_pkg::ACT_RESTART) ? IW'(0) : IW'(sl_r)] <=
        (in_action == idw_pkg::ACT_RESTART) ? {in_tmpl_z, in_tmpl_y, in_tmpl_x}
                                            : {in_sig_z, in_sig_y, in_sig_x};
    if (state_r == idw_pkg::S_RD) s_q <= smem[sj];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= idw_pkg::S_IDLE;
    else        state_r <= state_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      idw_pkg::S_IDLE: begin
        if (accept) begin
          if (in_action == idw_pkg::ACT_RESTART) state_nxt = idw_pkg::S_FRD;
          else if (tl_r == '0 || sl_r == '0) state_nxt = idw_pkg::S_DONE;
          else if ((need_t && tl_r >= LW'(idw_pkg::MAX_LEN)) ||
                   (need_s && sl_r >= LW'(idw_pkg::MAX_LEN)))
            state_nxt = idw_pkg::S_FRD;
          else state_nxt = idw_pkg::S_RD;
        end
      end
      idw_pkg::S_RD:   state_nxt = idw_pkg::S_SQ;
      idw_pkg::S_SQ:   if (cnt_r[1:0] == n_dims - 2'd1) state_nxt = idw_pkg::S_SQRT;
      idw_pkg::S_SQRT: if (cnt_r == 6'(idw_pkg::ROOT_W - 1)) state_nxt = idw_pkg::S_SEL;
      idw_pkg::S_SEL:  state_nxt = idw_pkg::S_SCL;
      idw_pkg::S_SCL:  state_nxt = idw_pkg::S_WR;
      idw_pkg::S_WR: begin
        if (LW'(pos_r) != last_pos || pend_col_r) state_nxt = idw_pkg::S_RD;
        else state_nxt = idw_pkg::S_FRD;
      end
      idw_pkg::S_FRD:  state_nxt = idw_pkg::S_FLAT;
      idw_pkg::S_FLAT: state_nxt = (c_q[SW-1:0] == '0) ? idw_pkg::S_DONE : idw_pkg::S_DIV;
      idw_pkg::S_DIV:  if (cnt_r == 6'(CW - 1)) state_nxt = idw_pkg::S_DONE;
      idw_pkg::S_DONE: if (load_out) state_nxt = idw_pkg::S_IDLE;
      default:         state_nxt = idw_pkg::S_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ff_r   <= 16'd32768;
      dims_r <= 2'd3;
      tl_r   <= '0;
      sl_r   <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (idw_pkg::cfg_idx_t'(cfg_index))
          idw_pkg::CFG_FORGET: ff_r   <= cfg_data;
          idw_pkg::CFG_DIMS:   dims_r <= cfg_data[1:0];
        endcase
      end
      if (accept && in_action == idw_pkg::ACT_RESTART) begin
        tl_r <= LW'(1);
        sl_r <= LW'(1);
      end else if (state_r == idw_pkg::S_IDLE && state_nxt == idw_pkg::S_RD) begin
        if (need_t) tl_r <= tl_r + LW'(1);
        else        sl_r <= sl_r + LW'(1);
      end else if (state_r == idw_pkg::S_WR && LW'(pos_r) == last_pos && pend_col_r) begin
        sl_r <= sl_r + LW'(1);
      end
      if (load_out) out_valid <= 1'b1;
      else if (!out_stall) out_valid <= 1'b0;
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    unique case (state_r)
      idw_pkg::S_IDLE: begin
        pos_r      <= '0;
        cnt_r      <= '0;
        if (in_action == idw_pkg::ACT_RESTART) status_r <= idw_pkg::ST_OK;
        else if (tl_r == '0 || sl_r == '0) status_r <= idw_pkg::ST_NO_START;
        else if ((need_t && tl_r >= LW'(idw_pkg::MAX_LEN)) ||
                 (need_s && sl_r >= LW'(idw_pkg::MAX_LEN)))
          status_r <= idw_pkg::ST_FULL;
        else status_r <= idw_pkg::ST_OK;
        pass_col_r <= !need_t;
        pend_col_r <= need_t && need_s;
        line_r     <= need_t ? IW'(tl_r) : IW'(sl_r);
        dq_r       <= '0;
        div_r      <= '0;
      end
      idw_pkg::S_RD: begin
        acc_r <= '0;
        cnt_r <= '0;
      end
      idw_pkg::S_SQ: begin
        acc_r <= acc_r + prod[idw_pkg::RAD_W-1:0];
        cnt_r <= (cnt_r[1:0] == n_dims - 2'd1) ? '0 : cnt_r + 6'd1;
        rem_r  <= '0;
        root_r <= '0;
      end
      idw_pkg::S_SQRT: begin
        acc_r <= {acc_r[idw_pkg::RAD_W-3:0], 2'b00};
        cnt_r <= cnt_r + 6'd1;
        if (rem_sh >= trial) begin
          rem_r  <= rem_sh - trial;
          root_r <= {root_r[idw_pkg::ROOT_W-2:0], 1'b1};
        end else begin
          rem_r  <= rem_sh;
          root_r <= {root_r[idw_pkg::ROOT_W-2:0], 1'b0};
        end
      end
      idw_pkg::S_SEL: begin
        if (pos_r == '0) begin
          pred_r <= side_c;
          ps_r   <= side_s;
        end else if (dg_c_r <= l_c && dg_c_r <= u_c) begin
          pred_r <= dg_c_r;
          ps_r   <= dg_s_r;
        end else if (l_c <= u_c) begin
          pred_r <= l_c;
          ps_r   <= l_s;
        end else begin
          pred_r <= u_c;
          ps_r   <= u_s;
        end
      end
      idw_pkg::S_SCL: begin
        if (pos_r == '0) scaled_r <= pred_r;
        else if (prod[idw_pkg::PROD_W-1:CW+15] != '0) scaled_r <= idw_pkg::COST_MAX;
        else scaled_r <= prod[CW+14:15];
      end
      idw_pkg::S_WR: begin
        run_c_r <= new_c;
        run_s_r <= new_s;
        dg_c_r  <= side_c;
        dg_s_r  <= side_s;
        if (LW'(pos_r) == last_pos) begin
          pos_r      <= '0;
          pass_col_r <= 1'b1;
          pend_col_r <= 1'b0;
          line_r     <= IW'(sl_r);
        end else begin
          pos_r <= pos_r + IW'(1);
        end
      end
      idw_pkg::S_FRD: cnt_r <= '0;
      idw_pkg::S_FLAT: begin
        dq_r  <= side_c;
        div_r <= side_s;
        rm_r  <= '0;
        pred_r <= side_c;
      end
      idw_pkg::S_DIV: begin
        cnt_r <= cnt_r + 6'd1;
        if (dv >= {1'b0, div_r}) begin
          rm_r <= SW'(dv - {1'b0, div_r});
          dq_r <= {dq_r[CW-2:0], 1'b1};
        end else begin
          rm_r <= dv[SW-1:0];
          dq_r <= {dq_r[CW-2:0], 1'b0};
        end
      end
      idw_pkg::S_DONE: begin
        if (load_out) begin
          out_status <= status_r;
          if (status_r == idw_pkg::ST_NO_START) begin
            out_total_cost   <= '0;
            out_path_steps   <= '0;
            out_avg_distance <= '0;
          end else begin
            out_total_cost   <= pred_r;
            out_path_steps   <= div_r;
            if (div_r == '0) out_avg_distance <= '0;
            else if (dq_r[CW-1:32] != '0) out_avg_distance <= '1;
            else out_avg_distance <= dq_r[31:0];
          end
        end
      end
      default: ;
    endcase
  end

  a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
    tl_r <= LW'(idw_pkg::MAX_LEN) && sl_r <= LW'(idw_pkg::MAX_LEN))
    else $error("sequence length past table size");

  a_pos_bound: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == idw_pkg::S_WR |-> LW'(pos_r) <= last_pos)
    else $error("cell position past end of line");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_total_cost))
    else $error("stalled result changed");

endmodule
